// ===== design/ufcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ufcb_pkg: shared types and constants for the serial-line buffer engine
// Command codes, register indexes, the queued command and the result record.
// ----------------------------------------------------------------------------
package ufcb_pkg;

   // request mode codes as they arrive on the port
   localparam logic [2:0] MODE_RX_BYTE   = 3'd0;
   localparam logic [2:0] MODE_READ      = 3'd1;
   localparam logic [2:0] MODE_PUT       = 3'd2;
   localparam logic [2:0] MODE_TX_READY  = 3'd3;
   localparam logic [2:0] MODE_MODEM     = 3'd4;
   localparam logic [2:0] MODE_CANCEL_RX = 3'd5;
   localparam logic [2:0] MODE_CANCEL_TX = 3'd6;

   // configuration register indexes
   localparam logic [2:0] CSR_XOFF_CHAR  = 3'd0;
   localparam logic [2:0] CSR_RAW_MODE   = 3'd1;
   localparam logic [2:0] CSR_LOCAL_LINE = 3'd2;
   localparam logic [2:0] CSR_RX_HIGH    = 3'd3;
   localparam logic [2:0] CSR_RX_LOW     = 3'd4;
   localparam logic [2:0] CSR_TX_LOW     = 3'd5;

   localparam int WATER_W = 13;
   localparam int LEVEL_W = 13;

   localparam logic [7:0]         XOFF_RESET    = 8'd19;
   localparam logic [WATER_W-1:0] RX_HIGH_RESET = 13'd3072;
   localparam logic [WATER_W-1:0] RX_LOW_RESET  = 13'd1024;
   localparam logic [WATER_W-1:0] TX_LOW_RESET  = 13'd1024;

   typedef enum logic [2:0] {
      OP_RX_BYTE,
      OP_READ,
      OP_PUT,
      OP_TX_READY,
      OP_MODEM,
      OP_CANCEL_RX,
      OP_CANCEL_TX,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       line_overrun;
      logic       tx_empty;
      logic       cts_in;
      logic       dcd_in;
      logic       dsr_in;
   } cmd_type;

   typedef struct packed {
      logic [7:0]         byte_out;
      logic               byte_valid;
      logic               rts_out;
      logic [LEVEL_W-1:0] rx_level;
      logic [LEVEL_W-1:0] tx_level;
      logic               soft_ready;
      logic               peer_ready;
      logic               hung_up;
      logic               notify;
      logic               tx_done;
      logic               tx_irq_enable;
      logic [15:0]        overrun_total;
   } rsp_type;

   typedef enum logic {
      ST_EXEC,
      ST_FETCH
   } st_type;

endpackage

// ===== design/uart_flow_controlled_buffers.sv =====
// ----------------------------------------------------------------------------
// uart_flow_controlled_buffers: serial-line buffer engine
// Receive and transmit rings with RTS and XON/XOFF flow control.
// ----------------------------------------------------------------------------
//  channel | ports                        | transfer when
//  --------+------------------------------+------------------------------
//  request | req_push, req_full, req_*    | req_push && !req_full
//  result  | rsp_pop, rsp_empty, rsp_*    | rsp_pop && !rsp_empty
//  config  | csr_we, csr_index, csr_wdata | csr_we
//
//  A command with no ring byte to fetch is answered in the cycle it is taken;
//  a read or send that fetches one passes the fetch state (registered read port).
//  Requests and results each pass a two-entry queue, so the front keeps
//  taking requests while results wait to be popped.
//  Reset is synchronous; ring contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module uart_flow_controlled_buffers #(
   parameter int RX_DEPTH = 4096,
   parameter int TX_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_data,
   input  logic        req_line_overrun,
   input  logic        req_tx_empty,
   input  logic        req_cts_in,
   input  logic        req_dcd_in,
   input  logic        req_dsr_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_byte_valid,
   output logic        rsp_rts_out,
   output logic [12:0] rsp_rx_level,
   output logic [12:0] rsp_tx_level,
   output logic        rsp_soft_ready,
   output logic        rsp_peer_ready,
   output logic        rsp_hung_up,
   output logic        rsp_notify,
   output logic        rsp_tx_done,
   output logic        rsp_tx_irq_enable,
   output logic [15:0] rsp_overrun_total
);
   import ufcb_pkg::*;

   logic    cmd_valid, cmd_take;
   cmd_type cmd;
   logic    rsp_in_push, rsp_in_full;
   rsp_type rsp_in, rsp_head;

   ufcb_front u_front (
      .clock, .reset, .req_push, .req_full, .req_mode, .req_data,
      .req_line_overrun, .req_tx_empty, .req_cts_in, .req_dcd_in, .req_dsr_in,
      .cmd_valid, .cmd, .cmd_take
   );

   ufcb_back #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .cmd_valid, .cmd, .cmd_take, .rsp_in_push, .rsp_in, .rsp_in_full
   );

   ufcb_rspq u_rspq (
      .clock, .reset, .rsp_in_push, .rsp_in, .rsp_in_full,
      .rsp_pop, .rsp_empty, .rsp_head
   );

   assign rsp_byte_out      = rsp_head.byte_out;
   assign rsp_byte_valid    = rsp_head.byte_valid;
   assign rsp_rts_out       = rsp_head.rts_out;
   assign rsp_rx_level      = rsp_head.rx_level;
   assign rsp_tx_level      = rsp_head.tx_level;
   assign rsp_soft_ready    = rsp_head.soft_ready;
   assign rsp_peer_ready    = rsp_head.peer_ready;
   assign rsp_hung_up       = rsp_head.hung_up;
   assign rsp_notify        = rsp_head.notify;
   assign rsp_tx_done       = rsp_head.tx_done;
   assign rsp_tx_irq_enable = rsp_head.tx_irq_enable;
   assign rsp_overrun_total = rsp_head.overrun_total;

endmodule

// ===== design/ufcb_front.sv =====
// ----------------------------------------------------------------------------
// ufcb_front: request intake
// Decodes the mode of each request and holds up to two commands for the engine.
// ----------------------------------------------------------------------------
module ufcb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_mode,
   input  logic [7:0]          req_data,
   input  logic                req_line_overrun,
   input  logic                req_tx_empty,
   input  logic                req_cts_in,
   input  logic                req_dcd_in,
   input  logic                req_dsr_in,
   output logic                cmd_valid,
   output ufcb_pkg::cmd_type   cmd,
   input  logic                cmd_take
);
   import ufcb_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   cmd_type    decoded;

   // classify the mode code
   always_comb begin
      decoded.data         = req_data;
      decoded.line_overrun = req_line_overrun;
      decoded.tx_empty     = req_tx_empty;
      decoded.cts_in       = req_cts_in;
      decoded.dcd_in       = req_dcd_in;
      decoded.dsr_in       = req_dsr_in;
      unique case (req_mode)
         MODE_RX_BYTE:   decoded.op = OP_RX_BYTE;
         MODE_READ:      decoded.op = OP_READ;
         MODE_PUT:       decoded.op = OP_PUT;
         MODE_TX_READY:  decoded.op = OP_TX_READY;
         MODE_MODEM:     decoded.op = OP_MODEM;
         MODE_CANCEL_RX: decoded.op = OP_CANCEL_RX;
         MODE_CANCEL_TX: decoded.op = OP_CANCEL_TX;
         default:        decoded.op = OP_NONE;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ cmd_take;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the decoded command
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== design/ufcb_rspq.sv =====
// ----------------------------------------------------------------------------
// ufcb_rspq: result queue
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module ufcb_rspq (
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_in_push,
   input  ufcb_pkg::rsp_type   rsp_in,
   output logic                rsp_in_full,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output ufcb_pkg::rsp_type   rsp_head
);
   import ufcb_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop_ok;

   assign rsp_empty   = (count_ff == 2'd0);
   assign rsp_in_full = (count_ff == 2'd2);
   assign pop_ok      = rsp_pop && !rsp_empty;
   assign rsp_head    = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ rsp_in_push;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + {1'b0, rsp_in_push} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_in_push) begin
         slot_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ===== design/ufcb_back.sv =====
// ----------------------------------------------------------------------------
// ufcb_back: ring engine
// Executes commands against the receive and transmit rings and flow state.
// ----------------------------------------------------------------------------
module ufcb_back #(
   parameter int RX_DEPTH = 4096,
   parameter int TX_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [12:0]         csr_wdata,
   input  logic                cmd_valid,
   input  ufcb_pkg::cmd_type   cmd,
   output logic                cmd_take,
   output logic                rsp_in_push,
   output ufcb_pkg::rsp_type   rsp_in,
   input  logic                rsp_in_full
);
   import ufcb_pkg::*;

   localparam int RAW = $clog2(RX_DEPTH);
   localparam int RFW = $clog2(RX_DEPTH + 1);
   localparam int TAW = $clog2(TX_DEPTH);
   localparam int TFW = $clog2(TX_DEPTH + 1);
   localparam int RCW = (RFW > WATER_W) ? RFW : WATER_W;
   localparam int TCW = (TFW > WATER_W) ? TFW : WATER_W;

   // configuration
   logic [7:0]         xoff_ff;
   logic               raw_ff;
   logic               local_ff;
   logic [WATER_W-1:0] rx_high_ff, rx_low_ff, tx_low_ff;

   // ring state
   logic [7:0]     rx_mem [RX_DEPTH];
   logic [7:0]     tx_mem [TX_DEPTH];
   logic [7:0]     rx_q_ff, tx_q_ff;
   logic [RAW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic [RFW-1:0] rx_fill_ff, rx_fill_in;
   logic [TAW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic [TFW-1:0] tx_fill_ff, tx_fill_in;

   // flow state
   logic        rts_ff, rts_in;
   logic        done_ff, done_in;
   logic        peer_ff, peer_in;
   logic        queued_ff, queued_in;
   logic        soft_ff, soft_in;
   logic        hup_ff, hup_in;
   logic        mask_ff, mask_in;
   logic [15:0] ovr_ff, ovr_in;

   // control
   st_type  state_ff, state_in;
   rsp_type hold_ff, rsp_now;
   logic    fetch_rx_ff;
   logic    rx_we, tx_we, rx_re, tx_re;
   logic    need_fetch;
   logic    send;
   logic    note;
   logic    valid;
   logic [7:0] byte_now;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xoff_ff    <= XOFF_RESET;
         raw_ff     <= 1'b1;
         local_ff   <= 1'b0;
         rx_high_ff <= RX_HIGH_RESET;
         rx_low_ff  <= RX_LOW_RESET;
         tx_low_ff  <= TX_LOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_XOFF_CHAR:  xoff_ff    <= csr_wdata[7:0];
            CSR_RAW_MODE:   raw_ff     <= csr_wdata[0];
            CSR_LOCAL_LINE: local_ff   <= csr_wdata[0];
            CSR_RX_HIGH:    rx_high_ff <= csr_wdata;
            CSR_RX_LOW:     rx_low_ff  <= csr_wdata;
            CSR_TX_LOW:     tx_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cmd_take = (state_ff == ST_EXEC) && cmd_valid && !rsp_in_full;

   // work out the command: next state, ring accesses, result
   always_comb begin
      rx_wp_in   = rx_wp_ff;
      rx_rp_in   = rx_rp_ff;
      rx_fill_in = rx_fill_ff;
      tx_wp_in   = tx_wp_ff;
      tx_rp_in   = tx_rp_ff;
      tx_fill_in = tx_fill_ff;
      rts_in     = rts_ff;
      done_in    = done_ff;
      peer_in    = peer_ff;
      queued_in  = queued_ff;
      soft_in    = soft_ff;
      hup_in     = hup_ff;
      mask_in    = mask_ff;
      ovr_in     = ovr_ff;
      rx_we      = 1'b0;
      tx_we      = 1'b0;
      rx_re      = 1'b0;
      tx_re      = 1'b0;
      send       = 1'b0;
      note       = 1'b0;
      valid      = 1'b0;
      byte_now   = 8'd0;
      if (cmd_take) begin
         unique case (cmd.op)
            OP_RX_BYTE: begin
               if (cmd.line_overrun) ovr_in = ovr_ff + 16'd1;
               if (!raw_ff) soft_in = (cmd.data != xoff_ff);
               if (rx_fill_ff < RFW'(RX_DEPTH)) begin
                  rx_fill_in = rx_fill_ff + RFW'(1);
                  if (RCW'(rx_fill_in) == RCW'(rx_high_ff)) rts_in = 1'b0;
                  rx_we    = 1'b1;
                  rx_wp_in = (rx_wp_ff == RAW'(RX_DEPTH - 1)) ? '0 : rx_wp_ff + RAW'(1);
                  if (rx_fill_ff == '0) note = 1'b1;
               end
            end
            OP_READ: begin
               if (!local_ff) hup_in = 1'b0;
               if (!local_ff && hup_ff) begin
                  note = 1'b1;
               end else if (rx_fill_ff != '0) begin
                  rx_re      = 1'b1;
                  valid      = 1'b1;
                  rx_rp_in   = (rx_rp_ff == RAW'(RX_DEPTH - 1)) ? '0 : rx_rp_ff + RAW'(1);
                  rx_fill_in = rx_fill_ff - RFW'(1);
                  if (!rts_ff && RCW'(rx_fill_in) < RCW'(rx_low_ff)) rts_in = 1'b1;
               end
            end
            OP_PUT: begin
               if (tx_fill_ff < TFW'(TX_DEPTH)) begin
                  tx_we      = 1'b1;
                  tx_wp_in   = (tx_wp_ff == TAW'(TX_DEPTH - 1)) ? '0 : tx_wp_ff + TAW'(1);
                  tx_fill_in = tx_fill_ff + TFW'(1);
                  queued_in  = 1'b1;
                  done_in    = 1'b0;
                  send       = cmd.tx_empty && peer_ff && soft_ff;
               end
            end
            OP_TX_READY: begin
               send = peer_ff && queued_ff && soft_ff && (tx_fill_ff != '0);
            end
            OP_MODEM: begin
               if (cmd.dsr_in && !cmd.dcd_in) begin
                  hup_in = 1'b1;
                  note   = 1'b1;
               end
               peer_in = cmd.cts_in || local_ff;
            end
            OP_CANCEL_RX: begin
               rx_fill_in = '0;
               rx_rp_in   = rx_wp_ff;
               rts_in     = 1'b1;
            end
            OP_CANCEL_TX: begin
               done_in    = 1'b0;
               queued_in  = 1'b0;
               tx_fill_in = '0;
               tx_rp_in   = tx_wp_ff;
            end
            default: ;
         endcase
         // send one queued byte; an empty ring before a put sends the put byte
         if (send) begin
            valid = 1'b1;
            if (cmd.op == OP_PUT && tx_fill_ff == '0) begin
               byte_now = cmd.data;
            end else begin
               tx_re = 1'b1;
            end
            tx_rp_in   = (tx_rp_ff == TAW'(TX_DEPTH - 1)) ? '0 : tx_rp_ff + TAW'(1);
            tx_fill_in = tx_fill_in - TFW'(1);
            if (tx_fill_in == '0) begin
               done_in   = 1'b1;
               queued_in = 1'b0;
               note      = 1'b1;
               mask_in   = 1'b0;
            end else begin
               if (TCW'(tx_fill_in) == TCW'(tx_low_ff)) note = 1'b1;
               mask_in = 1'b1;
            end
         end
      end
      need_fetch = rx_re || tx_re;
      rsp_now.byte_out      = byte_now;
      rsp_now.byte_valid    = valid;
      rsp_now.rts_out       = rts_in;
      rsp_now.rx_level      = LEVEL_W'(rx_fill_in);
      rsp_now.tx_level      = LEVEL_W'(tx_fill_in);
      rsp_now.soft_ready    = soft_in;
      rsp_now.peer_ready    = peer_in;
      rsp_now.hung_up       = hup_in;
      rsp_now.notify        = note;
      rsp_now.tx_done       = done_in;
      rsp_now.tx_irq_enable = mask_in;
      rsp_now.overrun_total = ovr_in;
   end

   // next state
   always_comb begin
      unique case (state_ff)
         ST_EXEC:  state_in = (cmd_take && need_fetch) ? ST_FETCH : ST_EXEC;
         ST_FETCH: state_in = ST_EXEC;
         default:  state_in = ST_EXEC;
      endcase
   end

   // outputs: finish a fetched result or transfer the current one
   always_comb begin
      rsp_in = rsp_now;
      unique case (state_ff)
         ST_FETCH: begin
            rsp_in_push     = 1'b1;
            rsp_in          = hold_ff;
            rsp_in.byte_out = fetch_rx_ff ? rx_q_ff : tx_q_ff;
         end
         default: begin
            rsp_in_push = cmd_take && !need_fetch;
         end
      endcase
   end

   // control and flow registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_EXEC;
         rx_wp_ff   <= '0;
         rx_rp_ff   <= '0;
         rx_fill_ff <= '0;
         tx_wp_ff   <= '0;
         tx_rp_ff   <= '0;
         tx_fill_ff <= '0;
         rts_ff     <= 1'b1;
         done_ff    <= 1'b0;
         peer_ff    <= 1'b0;
         queued_ff  <= 1'b0;
         soft_ff    <= 1'b1;
         hup_ff     <= 1'b0;
         mask_ff    <= 1'b0;
         ovr_ff     <= 16'd0;
      end else begin
         state_ff   <= state_in;
         rx_wp_ff   <= rx_wp_in;
         rx_rp_ff   <= rx_rp_in;
         rx_fill_ff <= rx_fill_in;
         tx_wp_ff   <= tx_wp_in;
         tx_rp_ff   <= tx_rp_in;
         tx_fill_ff <= tx_fill_in;
         rts_ff     <= rts_in;
         done_ff    <= done_in;
         peer_ff    <= peer_in;
         queued_ff  <= queued_in;
         soft_ff    <= soft_in;
         hup_ff     <= hup_in;
         mask_ff    <= mask_in;
         ovr_ff     <= ovr_in;
      end
   end

   // park the result while the ring byte is read
   always_ff @(posedge clock) begin
      if (cmd_take && need_fetch) begin
         hold_ff     <= rsp_now;
         fetch_rx_ff <= rx_re;
      end
   end

   // receive ring
   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_wp_ff] <= cmd.data;
      if (rx_re) rx_q_ff <= rx_mem[rx_rp_ff];
   end

   // transmit ring
   always_ff @(posedge clock) begin
      if (tx_we) tx_mem[tx_wp_ff] <= cmd.data;
      if (tx_re) tx_q_ff <= tx_mem[tx_rp_ff];
   end

endmodule

// ===== design/ufcb_check.sv =====
// ----------------------------------------------------------------------------
// ufcb_check: port-level checks for the buffer engine
// Watches the result channel for consistency of the reported status.
// ----------------------------------------------------------------------------
module ufcb_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_byte_out,
   input logic        rsp_byte_valid,
   input logic [12:0] rsp_tx_level,
   input logic        rsp_tx_done,
   input logic        rsp_tx_irq_enable
);

   // no byte means a zero byte
   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_byte_valid) |-> (rsp_byte_out == 8'd0))
      else $error("byte_out nonzero without byte_valid");

   // done implies a drained ring
   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_tx_done) |-> (rsp_tx_level == 13'd0))
      else $error("tx_done with bytes still queued");

   // done masks the transmit interrupt
   a_done_masked: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_tx_done) |-> !rsp_tx_irq_enable)
      else $error("tx_done with transmit interrupt enabled");

   // reset drops all results
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result waiting after reset");

   // a waiting result stays until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result vanished without pop");

endmodule

bind uart_flow_controlled_buffers ufcb_check u_check (.*);
